>>> src/jdc_pkg.sv
// ----------------------------------------------------------------------------
// jdc_pkg : shared types, constants and tables of the Julian day converter
// Calendar constants, reciprocals for the constant dividers, month tables and
// the bundles that travel between the converter modules.
// ----------------------------------------------------------------------------
package jdc_pkg;

    // pipeline depth: register stages from the accepting edge to the outputs
    localparam int PIPE_LAST = 12;

    // calendar constants
    localparam int JD_BIAS       = 32045;
    localparam int JD_BIAS_INV   = 32044;
    localparam int DAYS_400Y     = 146097;
    localparam int DAYS_4Y       = 1461;
    localparam int MONTH_SPAN    = 153;
    localparam int YEAR_BIAS     = 4800;
    localparam int DAYS_YEAR     = 365;
    localparam int MONTH_FEB     = 2;
    localparam int FEB_LEAP_DAYS = 29;
    localparam int WRAP_MONTH    = 10;

    // year offsets, multiples of 400 so the leap and century rules are unchanged
    localparam int DIV_YEAR_BIAS = 12000;
    localparam int LEAP_BIAS     = 16400;
    localparam int DATE_Y_BIAS   = YEAR_BIAS + DIV_YEAR_BIAS;

    // constant part of the date to day number sum once the year is offset
    localparam int JD_NUM_BIAS = DAYS_YEAR * DIV_YEAR_BIAS + DIV_YEAR_BIAS / 4
                               - DIV_YEAR_BIAS / 100 + DIV_YEAR_BIAS / 400 + JD_BIAS;

    // weekday offset: a multiple of 7 that keeps every day number positive
    localparam int WEEK_BIAS = 7 * 1200000;

    // reciprocals: estimate = (x * REC) >> SH, low by at most one
    localparam int REC_400Y_SH = 32;
    localparam longint REC_400Y = (64'd1 << REC_400Y_SH) / DAYS_400Y;
    localparam int REC_4Y_SH = 24;
    localparam longint REC_4Y = (64'd1 << REC_4Y_SH) / DAYS_4Y;
    localparam int REC_MON_SH = 16;
    localparam longint REC_MON = (64'd1 << REC_MON_SH) / MONTH_SPAN;
    localparam int REC_100_SH = 16;
    localparam longint REC_100 = (64'd1 << REC_100_SH) / 100;
    localparam int REC_7_SH = 27;
    localparam longint REC_7 = (64'd1 << REC_7_SH) / 7;

    // one item on its way through the front of the pipeline
    typedef struct packed {
        logic               cmd;
        logic signed [14:0] year;
        logic [3:0]         month;
        logic [4:0]         day;
        logic signed [23:0] num;
    } t_item;

    // date computed from a day number, year before the 15-bit wrap
    typedef struct packed {
        logic signed [15:0] year;
        logic [3:0]         month;
        logic [4:0]         day;
    } t_date;

    // days from March 1 to the start of shifted month m: (153 m + 2) / 5
    function automatic logic [8:0] f_month_off(input logic [3:0] m);
        logic [8:0] off;
        case (m)
            4'd0:    off = 9'd0;
            4'd1:    off = 9'd31;
            4'd2:    off = 9'd61;
            4'd3:    off = 9'd92;
            4'd4:    off = 9'd122;
            4'd5:    off = 9'd153;
            4'd6:    off = 9'd184;
            4'd7:    off = 9'd214;
            4'd8:    off = 9'd245;
            4'd9:    off = 9'd275;
            4'd10:   off = 9'd306;
            4'd11:   off = 9'd337;
            4'd12:   off = 9'd367;
            default: off = 9'd0;
        endcase
        return off;
    endfunction

    // calendar month to March-based month (January and February move to the end)
    function automatic logic [3:0] f_shift_month(input logic [3:0] month);
        logic [3:0] m;
        if (month <= 4'(MONTH_FEB)) begin
            m = month + 4'd9;
        end else begin
            m = month - 4'd3;
        end
        return m;
    endfunction

    // days in a month of a common year, zero for a month code out of range
    function automatic logic [4:0] f_month_days(input logic [3:0] month);
        logic [4:0] len;
        case (month)
            4'd1, 4'd3, 4'd5, 4'd7, 4'd8, 4'd10, 4'd12: len = 5'd31;
            4'd4, 4'd6, 4'd9, 4'd11:                    len = 5'd30;
            4'd2:                                       len = 5'd28;
            default:                                    len = 5'd0;
        endcase
        return len;
    endfunction

endpackage

>>> src/jdc_num2date.sv
// ----------------------------------------------------------------------------
// jdc_num2date : day number to Gregorian date, nine register stages
// Splits the day number into 400-year cycles, 4-year cycles and a shifted
// month, each constant division as estimate, multiply back and correction.
// ----------------------------------------------------------------------------
module jdc_num2date (
    input  logic          i_clk,
    input  logic [22:0]   i_number,
    output jdc_pkg::t_date o_date
);

    // stage 1: shift the epoch, estimate the 400-year cycle
    logic [23:0] w_a;
    logic [25:0] w_x;
    logic [40:0] w_bprod;
    logic [23:0] r1_a;
    logic [25:0] r1_x;
    logic [7:0]  r1_bq;

    assign w_a     = 24'(i_number) + 24'(jdc_pkg::JD_BIAS_INV);
    assign w_x     = {w_a, 2'b11};
    assign w_bprod = 41'(w_x) * 41'(jdc_pkg::REC_400Y);

    always_ff @(posedge i_clk) begin
        r1_a  <= w_a;
        r1_x  <= w_x;
        r1_bq <= w_bprod[jdc_pkg::REC_400Y_SH +: 8];
    end

    // stage 2: multiply the estimate back
    logic [23:0] r2_a;
    logic [25:0] r2_x;
    logic [7:0]  r2_bq;
    logic [25:0] r2_bp;

    always_ff @(posedge i_clk) begin
        r2_a  <= r1_a;
        r2_x  <= r1_x;
        r2_bq <= r1_bq;
        r2_bp <= 26'(r1_bq) * 26'(jdc_pkg::DAYS_400Y);
    end

    // stage 3: correct the cycle count, day within the cycle
    logic [25:0] w_rem1;
    logic        w_hit1;
    logic [25:0] w_bpf;
    logic [23:0] w_c;
    logic [7:0]  r3_b;
    logic [15:0] r3_c;

    assign w_rem1 = r2_x - r2_bp;
    assign w_hit1 = (w_rem1 >= 26'(jdc_pkg::DAYS_400Y));
    assign w_bpf  = r2_bp + (w_hit1 ? 26'(jdc_pkg::DAYS_400Y) : 26'd0);
    assign w_c    = r2_a - w_bpf[25:2];

    always_ff @(posedge i_clk) begin
        r3_b <= r2_bq + 8'(w_hit1);
        r3_c <= w_c[15:0];
    end

    // stage 4: estimate the 4-year cycle, centuries to years
    logic [17:0] w_x2;
    logic [31:0] w_dprod;
    logic [17:0] r4_x2;
    logic [6:0]  r4_dq;
    logic [15:0] r4_c;
    logic [14:0] r4_b100;

    assign w_x2    = {r3_c, 2'b11};
    assign w_dprod = 32'(w_x2) * 32'(jdc_pkg::REC_4Y);

    always_ff @(posedge i_clk) begin
        r4_x2   <= w_x2;
        r4_dq   <= w_dprod[jdc_pkg::REC_4Y_SH +: 7];
        r4_c    <= r3_c;
        r4_b100 <= 15'(r3_b) * 15'd100;
    end

    // stage 5: multiply the estimate back
    logic [17:0] r5_x2;
    logic [6:0]  r5_dq;
    logic [15:0] r5_c;
    logic [14:0] r5_b100;
    logic [17:0] r5_dp;

    always_ff @(posedge i_clk) begin
        r5_x2   <= r4_x2;
        r5_dq   <= r4_dq;
        r5_c    <= r4_c;
        r5_b100 <= r4_b100;
        r5_dp   <= 18'(r4_dq) * 18'(jdc_pkg::DAYS_4Y);
    end

    // stage 6: correct, day of the March-based year
    logic [17:0] w_rem2;
    logic        w_hit2;
    logic [17:0] w_dpf;
    logic [15:0] w_e;
    logic [8:0]  r6_e;
    logic [14:0] r6_yb;

    assign w_rem2 = r5_x2 - r5_dp;
    assign w_hit2 = (w_rem2 >= 18'(jdc_pkg::DAYS_4Y));
    assign w_dpf  = r5_dp + (w_hit2 ? 18'(jdc_pkg::DAYS_4Y) : 18'd0);
    assign w_e    = r5_c - w_dpf[17:2];

    always_ff @(posedge i_clk) begin
        r6_e  <= w_e[8:0];
        r6_yb <= r5_b100 + 15'(r5_dq) + 15'(w_hit2);
    end

    // stage 7: estimate the shifted month
    logic [10:0] w_x3;
    logic [19:0] w_mprod;
    logic [10:0] r7_x3;
    logic [3:0]  r7_mq;
    logic [8:0]  r7_e;
    logic [14:0] r7_yb;

    assign w_x3    = {r6_e, 2'b00} + 11'(r6_e) + 11'd2;
    assign w_mprod = 20'(w_x3) * 20'(jdc_pkg::REC_MON);

    always_ff @(posedge i_clk) begin
        r7_x3 <= w_x3;
        r7_mq <= w_mprod[jdc_pkg::REC_MON_SH +: 4];
        r7_e  <= r6_e;
        r7_yb <= r6_yb;
    end

    // stage 8: multiply the estimate back
    logic [10:0] r8_x3;
    logic [3:0]  r8_mq;
    logic [8:0]  r8_e;
    logic [14:0] r8_yb;
    logic [10:0] r8_mp;

    always_ff @(posedge i_clk) begin
        r8_x3 <= r7_x3;
        r8_mq <= r7_mq;
        r8_e  <= r7_e;
        r8_yb <= r7_yb;
        r8_mp <= 11'(r7_mq) * 11'(jdc_pkg::MONTH_SPAN);
    end

    // stage 9: correct the month, day of month, calendar month and year
    logic [10:0]    w_rem3;
    logic           w_hit3;
    logic [3:0]     w_m;
    logic           w_wrap;
    logic [8:0]     w_day;
    jdc_pkg::t_date n_date;
    jdc_pkg::t_date r_date;

    assign w_rem3 = r8_x3 - r8_mp;
    assign w_hit3 = (w_rem3 >= 11'(jdc_pkg::MONTH_SPAN));
    assign w_m    = r8_mq + 4'(w_hit3);
    assign w_wrap = (w_m >= 4'(jdc_pkg::WRAP_MONTH));
    assign w_day  = r8_e - jdc_pkg::f_month_off(w_m) + 9'd1;

    always_comb begin
        n_date.day   = w_day[4:0];
        n_date.month = w_wrap ? (w_m - 4'd9) : (w_m + 4'd3);
        n_date.year  = 16'(r8_yb) - 16'(jdc_pkg::YEAR_BIAS) + 16'(w_wrap);
    end

    always_ff @(posedge i_clk) begin
        r_date <= n_date;
    end

    assign o_date = r_date;

endmodule

>>> src/julian_day_date_converter_top.sv
// ----------------------------------------------------------------------------
// julian_day_date_converter_top : Gregorian date <-> Julian day number
// Proleptic Gregorian converter with weekday, leap flag and month length.
// ----------------------------------------------------------------------------
// Usage:
//   Command channel: a transfer takes place at each rising edge with start high
//   and busy low. busy is always low, so a command can be issued every cycle.
//   i_command 0 converts i_year_in / i_month_in / i_day_in to a day number,
//   i_command 1 converts i_number_in to a date; unused fields are ignored.
//   Result channel: o_done is high for exactly one cycle per command, with all
//   result fields valid in that cycle. Results come back in command order.
//   Throughput is one conversion per cycle. The depth of the pipeline is set by
//   the day number to date path: three constant divisions (400-year cycle,
//   4-year cycle, month), each an estimate multiply, a multiply back and a
//   correction, followed by the weekday and leap checks (divide by 7 and by
//   100).
//   Reset (i_rst_n low, synchronous) flushes all commands in flight; no
//   result is produced for them. The receiver cannot stall, so the pipeline
//   never holds.
// ----------------------------------------------------------------------------
module julian_day_date_converter_top (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               start,
    output logic               busy,
    input  logic               i_command,
    input  logic signed [14:0] i_year_in,
    input  logic [3:0]         i_month_in,
    input  logic [4:0]         i_day_in,
    input  logic [22:0]        i_number_in,
    output logic               o_done,
    output logic signed [23:0] o_number_out,
    output logic signed [14:0] o_year_out,
    output logic [3:0]         o_month_out,
    output logic [4:0]         o_day_out,
    output logic [2:0]         o_weekday,
    output logic               o_leap_year,
    output logic [4:0]         o_month_length,
    output logic               o_valid_res
);

    // the pipeline never holds
    assign busy = 1'b0;

    // valid bits, one per stage
    logic [jdc_pkg::PIPE_LAST:1] r_vld;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            r_vld <= {r_vld[jdc_pkg::PIPE_LAST-1:1], start & ~busy};
        end
    end

    // item payload, fixed taps of a delay line up to the merge stage
    jdc_pkg::t_item r_item [1:9];
    jdc_pkg::t_item n_item1;
    jdc_pkg::t_item n_item3;

    // stage 1: offset year, estimate centuries, day plus month offset
    logic               w_early;
    logic signed [16:0] w_ys;
    logic [15:0]        w_yp;
    logic [25:0]        w_yprod;
    logic [15:0]        r1_yp;
    logic [9:0]         r1_yq0;
    logic [9:0]         r1_dm;

    assign w_early = (i_month_in <= 4'(jdc_pkg::MONTH_FEB));
    assign w_ys    = {{2{i_year_in[14]}}, i_year_in} + 17'(jdc_pkg::DATE_Y_BIAS)
                   - 17'(w_early);
    assign w_yp    = w_ys[15:0];
    assign w_yprod = 26'(w_yp) * 26'(jdc_pkg::REC_100);

    always_comb begin
        n_item1.cmd   = i_command;
        n_item1.year  = i_year_in;
        n_item1.month = i_month_in;
        n_item1.day   = i_day_in;
        n_item1.num   = 24'(i_number_in);
    end

    always_ff @(posedge i_clk) begin
        r_item[1] <= n_item1;
        r1_yp     <= w_yp;
        r1_yq0    <= w_yprod[jdc_pkg::REC_100_SH +: 10];
        r1_dm     <= 10'(i_day_in)
                   + 10'(jdc_pkg::f_month_off(jdc_pkg::f_shift_month(i_month_in)));
    end

    // stage 2: century remainder, days of the whole years
    logic [16:0] w_q100p;
    logic [15:0] w_yrem1;
    logic [9:0]  r2_yq0;
    logic [7:0]  r2_yrem;
    logic [24:0] r2_sum;

    assign w_q100p = 17'(r1_yq0) * 17'd100;
    assign w_yrem1 = r1_yp - w_q100p[15:0];

    always_ff @(posedge i_clk) begin
        r_item[2] <= r_item[1];
        r2_yq0    <= r1_yq0;
        r2_yrem   <= w_yrem1[7:0];
        r2_sum    <= 25'(r1_yp) * 25'(jdc_pkg::DAYS_YEAR) + 25'(r1_yp[15:2]) + 25'(r1_dm);
    end

    // stage 3: correct centuries, finish the day number of a date
    logic [9:0]  w_q100;
    logic [25:0] w_num26;

    assign w_q100  = r2_yq0 + 10'(r2_yrem >= 8'd100);
    assign w_num26 = 26'(r2_sum) - 26'(w_q100) + 26'(w_q100[9:2])
                   - 26'(jdc_pkg::JD_NUM_BIAS);

    always_comb begin
        n_item3 = r_item[2];
        if (!r_item[2].cmd) begin
            n_item3.num = w_num26[23:0];
        end
    end

    always_ff @(posedge i_clk) begin
        r_item[3] <= n_item3;
    end

    // stages 4 to 9: wait for the date path
    always_ff @(posedge i_clk) begin
        r_item[4] <= r_item[3];
        r_item[5] <= r_item[4];
        r_item[6] <= r_item[5];
        r_item[7] <= r_item[6];
        r_item[8] <= r_item[7];
        r_item[9] <= r_item[8];
    end

    // day number to date, result at stage 9
    jdc_pkg::t_date w_date;

    jdc_num2date u_num2date (
        .i_clk    (i_clk),
        .i_number (i_number_in),
        .o_date   (w_date)
    );

    // stage 10: merge, estimate century of the year and week of the number
    logic signed [15:0] w_year_f;
    logic [3:0]         w_month_f;
    logic [4:0]         w_day_f;
    logic [16:0]        w_yo;
    logic [25:0]        w_lprod;
    logic [25:0]        w_wa;
    logic [49:0]        w_wprod;
    logic [15:0]        r10_yo;
    logic [9:0]         r10_yq0;
    logic [24:0]        r10_wa;
    logic [21:0]        r10_wq;
    logic signed [23:0] r10_num;
    logic signed [14:0] r10_year;
    logic [3:0]         r10_month;
    logic [4:0]         r10_day;
    logic               r10_pos;

    assign w_year_f  = r_item[9].cmd ? w_date.year
                                     : {r_item[9].year[14], r_item[9].year};
    assign w_month_f = r_item[9].cmd ? w_date.month : r_item[9].month;
    assign w_day_f   = r_item[9].cmd ? w_date.day : r_item[9].day;
    assign w_yo      = {w_year_f[15], w_year_f} + 17'(jdc_pkg::LEAP_BIAS);
    assign w_lprod   = 26'(w_yo[15:0]) * 26'(jdc_pkg::REC_100);
    assign w_wa      = {{2{r_item[9].num[23]}}, r_item[9].num}
                     + 26'(jdc_pkg::WEEK_BIAS + 1);
    assign w_wprod   = 50'(w_wa[24:0]) * 50'(jdc_pkg::REC_7);

    always_ff @(posedge i_clk) begin
        r10_yo    <= w_yo[15:0];
        r10_yq0   <= w_lprod[jdc_pkg::REC_100_SH +: 10];
        r10_wa    <= w_wa[24:0];
        r10_wq    <= w_wprod[jdc_pkg::REC_7_SH +: 22];
        r10_num   <= r_item[9].num;
        r10_year  <= w_year_f[14:0];
        r10_month <= w_month_f;
        r10_day   <= w_day_f;
        r10_pos   <= !r_item[9].num[23] && (r_item[9].num != 24'sd0);
    end

    // stage 11: remainders by 100 and by 7
    logic [16:0]        w_l100p;
    logic [16:0]        w_lrem;
    logic [24:0]        w_w7p;
    logic [24:0]        w_wrem;
    logic [1:0]         r11_yo2;
    logic [9:0]         r11_yq0;
    logic [7:0]         r11_yrem;
    logic [3:0]         r11_wrem;
    logic signed [23:0] r11_num;
    logic signed [14:0] r11_year;
    logic [3:0]         r11_month;
    logic [4:0]         r11_day;
    logic               r11_pos;

    assign w_l100p = 17'(r10_yq0) * 17'd100;
    assign w_lrem  = 17'(r10_yo) - w_l100p;
    assign w_w7p   = 25'(r10_wq) * 25'd7;
    assign w_wrem  = r10_wa - w_w7p;

    always_ff @(posedge i_clk) begin
        r11_yo2   <= r10_yo[1:0];
        r11_yq0   <= r10_yq0;
        r11_yrem  <= w_lrem[7:0];
        r11_wrem  <= w_wrem[3:0];
        r11_num   <= r10_num;
        r11_year  <= r10_year;
        r11_month <= r10_month;
        r11_day   <= r10_day;
        r11_pos   <= r10_pos;
    end

    // stage 12: leap rule, weekday, month length into the output registers
    logic       w_chit;
    logic [9:0] w_cent;
    logic       w_leap;
    logic [3:0] w_wd;

    assign w_chit = (r11_yrem >= 8'd100);
    assign w_cent = r11_yq0 + 10'(w_chit);
    assign w_leap = (r11_yo2 == 2'd0)
                 && (((r11_yrem != 8'd0) && (r11_yrem != 8'd100)) || (w_cent[1:0] == 2'd0));
    assign w_wd   = (r11_wrem >= 4'd7) ? (r11_wrem - 4'd7) : r11_wrem;

    always_ff @(posedge i_clk) begin
        o_number_out <= r11_num;
        o_year_out   <= r11_year;
        o_month_out  <= r11_month;
        o_day_out    <= r11_day;
        o_weekday    <= w_wd[2:0];
        o_leap_year  <= w_leap;
        o_valid_res  <= r11_pos;
        if ((r11_month == 4'(jdc_pkg::MONTH_FEB)) && w_leap) begin
            o_month_length <= 5'(jdc_pkg::FEB_LEAP_DAYS);
        end else begin
            o_month_length <= jdc_pkg::f_month_days(r11_month);
        end
    end

    assign o_done = r_vld[jdc_pkg::PIPE_LAST];

    // checks
    a_fixed_latency: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |-> ##(jdc_pkg::PIPE_LAST) o_done)
        else $error("command transfer without result after 12 cycles");

    a_no_spurious: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> $past(start && !busy, jdc_pkg::PIPE_LAST))
        else $error("result without a command transfer 12 cycles earlier");

    a_weekday_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> (o_weekday <= 3'd6))
        else $error("weekday out of range");

    a_month_len: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_done && (o_month_out >= 4'd1) && (o_month_out <= 4'd12))
        |-> ((o_month_length >= 5'd28) && (o_month_length <= 5'd31)))
        else $error("month length out of range for a valid month");

    a_leap_div4: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_done && o_leap_year) |-> (o_year_out[1:0] == 2'd0))
        else $error("leap flag on a year not divisible by four");

endmodule
